// ===== hw/rtl/dcsl_pkg.sv =====
// Package for the drive command slew limiter: field types, register codes,
// reset values and the constants of the fixed-point datapath.
// Depends on nothing; every other file in hw/rtl imports it.
package dcsl_pkg;

	// Field widths.
	localparam int unsigned CMD_W = 16;
	localparam int unsigned MAG_W = 16;
	localparam int unsigned CFG_W = 15;
	localparam int unsigned IDX_W = 3;

	// Axis values are Q1.14, so a product with a Q7.8 limit drops 14 bits.
	localparam int unsigned Q14_SHIFT = 14;

	// Update steps per second of the command loop.
	localparam int unsigned STEPS_PER_SECOND = 200;

	// Step quotient floor(x / STEPS_PER_SECOND) for x below 2**MAG_W is taken
	// as (x * RECIP_MULT) >> RECIP_SHIFT, exact over that whole range.
	localparam int unsigned RECIP_SHIFT = MAG_W + $clog2(STEPS_PER_SECOND);
	localparam longint unsigned RECIP_MULT =
		((64'd1 << RECIP_SHIFT) + STEPS_PER_SECOND - 1) / STEPS_PER_SECOND;
	localparam int unsigned RECIP_W = $clog2(RECIP_MULT + 1);
	localparam int unsigned RPROD_W = MAG_W + RECIP_W;
	localparam int unsigned STEP_W = $clog2(((2 ** MAG_W) - 1) / STEPS_PER_SECOND + 1);

	// Saturation bounds of a signed command, as magnitudes.
	localparam logic [MAG_W:0] POS_SAT = (MAG_W + 1)'(32767);
	localparam logic [MAG_W:0] NEG_SAT = (MAG_W + 1)'(32768);

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_MAX_SPEED = CFG_W'(2560);
	localparam logic [CFG_W-1:0] RST_MAX_ANGLE = CFG_W'(6400);
	localparam logic [CFG_W-1:0] RST_MAX_ANGLE_FAST = CFG_W'(5120);
	localparam logic [CFG_W-1:0] RST_RATE = CFG_W'(1024);

	typedef logic signed [CMD_W-1:0] axis_t;
	typedef logic signed [CMD_W-1:0] cmd_t;
	typedef logic [CFG_W-1:0] cfg_val_t;

	// Register indexes of the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_MAX_SPEED_FWD  = 3'd0,
		REG_MAX_SPEED_REV  = 3'd1,
		REG_MAX_ANGLE_R    = 3'd2,
		REG_MAX_ANGLE_L    = 3'd3,
		REG_MAX_ANGLE_FAST = 3'd4,
		REG_ACCEL_FWD      = 3'd5,
		REG_ACCEL_REV      = 3'd6,
		REG_STEER_RATE     = 3'd7
	} cfg_idx_t;

endpackage

// ===== hw/rtl/dcsl_in_if.sv =====
// Input channel of the slew limiter: one item holds the two joystick axes.
// Depends on dcsl_pkg.
interface dcsl_in_if import dcsl_pkg::*; ();
	logic  valid;
	logic  ready;
	axis_t speed_axis;
	axis_t steer_axis;

	modport source (output valid, output speed_axis, output steer_axis, input ready);
	modport sink (input valid, input speed_axis, input steer_axis, output ready);
endinterface

// ===== hw/rtl/dcsl_out_if.sv =====
// Output channel of the slew limiter: one item holds the new speed and
// steering commands. Depends on dcsl_pkg.
interface dcsl_out_if import dcsl_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t speed_cmd;
	cmd_t steer_cmd;

	modport source (output valid, output speed_cmd, output steer_cmd, input ready);
	modport sink (input valid, input speed_cmd, input steer_cmd, output ready);
endinterface

// ===== hw/rtl/dcsl_cfg_if.sv =====
// Configuration write channel of the slew limiter: register index and data.
// Depends on dcsl_pkg.
interface dcsl_cfg_if import dcsl_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_val_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/drive_command_slew_limiter_core.sv =====
// Drive command slew limiter: five-stage pipeline from joystick axes to
// rate-limited, saturated speed and steering commands.
// Depends on dcsl_pkg, dcsl_in_if, dcsl_out_if and dcsl_cfg_if.
//
// Usage:
//   cmd_in  carries one item per joystick sample: speed_axis and steer_axis,
//           signed Q1.14. An item is taken when valid and ready are high.
//   cmd_out carries one item per input item: speed_cmd and steer_cmd, signed
//           Q7.8. The steering command has the opposite sign of its axis.
//   cfg     writes one of eight 15-bit Q7.8 limit and rate registers; it is
//           always ready. Write it only while no item is in flight.
// An accepted item is registered in stages 1 to 5 in turn, and stage 5
// drives cmd_out. Throughput is one item per cycle while cmd_out is
// ready: the speed command loop closes within stage 4 and the steering
// loop within stage 5, with the multiplications in stages 2 and 3 ahead.
// Each stage holds its item until the next one frees, so a stalled receiver
// only blocks input once every stage is full; bubbles are closed up.
// Reset empties the pipeline, clears both commands to zero and loads the
// register reset values.
module drive_command_slew_limiter_core import dcsl_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	dcsl_in_if.sink        cmd_in,
	dcsl_out_if.source     cmd_out,
	dcsl_cfg_if.sink       cfg
);

	// Magnitude of a 16-bit two's complement value; the most negative one
	// gives 32768.
	function automatic logic [MAG_W:0] mag17(input cmd_t v);
		logic [MAG_W:0] ext;
		ext = {1'b0, v};
		return v[CMD_W-1] ? ((MAG_W + 1)'(2 ** MAG_W) - ext) : ext;
	endfunction

	// New magnitude is the smaller of old magnitude plus step and the
	// ceiling; then it is signed and saturated.
	function automatic cmd_t limit_sign(input logic [STEP_W-1:0] step, input cmd_t old,
			input logic [MAG_W-1:0] ceil_lim, input logic neg);
		logic [MAG_W:0] sum;
		logic [MAG_W:0] m;
		sum = (MAG_W + 1)'(step) + mag17(old);
		m = (sum > {1'b0, ceil_lim}) ? {1'b0, ceil_lim} : sum;
		if (neg) begin
			if (m > NEG_SAT) begin
				m = NEG_SAT;
			end
			return CMD_W'((MAG_W + 1)'(2 ** MAG_W) - m);
		end
		if (m > POS_SAT) begin
			m = POS_SAT;
		end
		return m[CMD_W-1:0];
	endfunction

	// Configuration registers.
	cfg_val_t max_speed_fwd_q, max_speed_rev_q;
	cfg_val_t max_angle_r_q, max_angle_l_q, max_angle_fast_q;
	cfg_val_t accel_fwd_q, accel_rev_q, steer_rate_q;

	// Stage valids and advance enables.
	logic v1, v2, v3, v4, v5;
	logic en1, en2, en3, en4, en5;

	// Stage 1: input register.
	axis_t speed_axis_s1, steer_axis_s1;

	// Stage 2: products scaled back to Q7.8.
	logic [MAG_W-1:0] s_pre_s2, s_ceil_s2, t_pre_s2, t_dir_ceil_s2, t_fast_ceil_s2;
	logic             s_neg_s2, t_pos_s2;

	// Stage 3: step quotients.
	logic [STEP_W-1:0] s_step_s3, t_step_s3;
	logic [MAG_W-1:0]  s_ceil_s3, t_dir_ceil_s3, t_fast_ceil_s3;
	logic              s_neg_s3, t_pos_s3;

	// Stage 4: speed command, which is also the speed state.
	cmd_t              speed_s4;
	logic [STEP_W-1:0] t_step_s4;
	logic [MAG_W-1:0]  t_dir_ceil_s4, t_fast_ceil_s4;
	logic              t_pos_s4;

	// Stage 5: output register; steer_s5 is also the steering state.
	cmd_t speed_s5, steer_s5;

	// Stage 2 combinational signals.
	logic [MAG_W:0]   s_mag, t_mag;
	logic             s_pos, s_neg, t_pos;
	cfg_val_t         accel_sel, vmax_sel, adir_sel;
	logic [31:0]      s_step_prod, s_ceil_prod, t_step_prod, t_dir_prod, t_fast_prod;

	// Stage 3 combinational signals.
	logic [RPROD_W-1:0] s_rprod, t_rprod;

	// Stage 5 combinational signals.
	logic [MAG_W:0]   v_mag;
	cfg_val_t         vmax_now;
	logic [MAG_W+2:0] v_mag_x5, vmax_x4;
	logic             fast;
	logic [MAG_W-1:0] amax_sel;

	// Configuration writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_fwd_q  <= RST_MAX_SPEED;
			max_speed_rev_q  <= RST_MAX_SPEED;
			max_angle_r_q    <= RST_MAX_ANGLE;
			max_angle_l_q    <= RST_MAX_ANGLE;
			max_angle_fast_q <= RST_MAX_ANGLE_FAST;
			accel_fwd_q      <= RST_RATE;
			accel_rev_q      <= RST_RATE;
			steer_rate_q     <= RST_RATE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_SPEED_FWD:  max_speed_fwd_q  <= cfg.data;
				REG_MAX_SPEED_REV:  max_speed_rev_q  <= cfg.data;
				REG_MAX_ANGLE_R:    max_angle_r_q    <= cfg.data;
				REG_MAX_ANGLE_L:    max_angle_l_q    <= cfg.data;
				REG_MAX_ANGLE_FAST: max_angle_fast_q <= cfg.data;
				REG_ACCEL_FWD:      accel_fwd_q      <= cfg.data;
				REG_ACCEL_REV:      accel_rev_q      <= cfg.data;
				REG_STEER_RATE:     steer_rate_q     <= cfg.data;
			endcase
		end
	end

	// A stage moves when the one after it is empty or moving too.
	always_comb begin
		en5 = !v5 || cmd_out.ready;
		en4 = !v4 || en5;
		en3 = !v3 || en4;
		en2 = !v2 || en3;
		en1 = !v1 || en2;
	end

	assign cmd_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (en1) begin
				v1 <= cmd_in.valid;
			end
			if (en2) begin
				v2 <= v1;
			end
			if (en3) begin
				v3 <= v2;
			end
			if (en4) begin
				v4 <= v3;
			end
			if (en5) begin
				v5 <= v4;
			end
		end
	end

	// Stage 1: capture the axes.
	always_ff @(posedge clk) begin
		if (en1 && cmd_in.valid) begin
			speed_axis_s1 <= cmd_in.speed_axis;
			steer_axis_s1 <= cmd_in.steer_axis;
		end
	end

	// Stage 2: select limits by axis sign and form the five products.
	always_comb begin
		s_mag = mag17(speed_axis_s1);
		t_mag = mag17(steer_axis_s1);
		s_neg = speed_axis_s1[CMD_W-1];
		s_pos = !s_neg && (speed_axis_s1 != '0);
		t_pos = !steer_axis_s1[CMD_W-1] && (steer_axis_s1 != '0);
		accel_sel = s_pos ? accel_fwd_q : accel_rev_q;
		vmax_sel = s_pos ? max_speed_fwd_q : max_speed_rev_q;
		adir_sel = t_pos ? max_angle_r_q : max_angle_l_q;
		s_step_prod = 32'(s_mag) * 32'(accel_sel);
		s_ceil_prod = 32'(s_mag) * 32'(vmax_sel);
		t_step_prod = 32'(t_mag) * 32'(steer_rate_q);
		t_dir_prod = 32'(t_mag) * 32'(adir_sel);
		t_fast_prod = 32'(t_mag) * 32'(max_angle_fast_q);
	end

	always_ff @(posedge clk) begin
		if (en2 && v1) begin
			s_pre_s2 <= s_step_prod[Q14_SHIFT +: MAG_W];
			s_ceil_s2 <= s_ceil_prod[Q14_SHIFT +: MAG_W];
			t_pre_s2 <= t_step_prod[Q14_SHIFT +: MAG_W];
			t_dir_ceil_s2 <= t_dir_prod[Q14_SHIFT +: MAG_W];
			t_fast_ceil_s2 <= t_fast_prod[Q14_SHIFT +: MAG_W];
			s_neg_s2 <= s_neg;
			t_pos_s2 <= t_pos;
		end
	end

	// Stage 3: divide the scaled rate products by the steps per second.
	always_comb begin
		s_rprod = RPROD_W'(s_pre_s2) * RPROD_W'(RECIP_MULT);
		t_rprod = RPROD_W'(t_pre_s2) * RPROD_W'(RECIP_MULT);
	end

	always_ff @(posedge clk) begin
		if (en3 && v2) begin
			s_step_s3 <= s_rprod[RECIP_SHIFT +: STEP_W];
			t_step_s3 <= t_rprod[RECIP_SHIFT +: STEP_W];
			s_ceil_s3 <= s_ceil_s2;
			t_dir_ceil_s3 <= t_dir_ceil_s2;
			t_fast_ceil_s3 <= t_fast_ceil_s2;
			s_neg_s3 <= s_neg_s2;
			t_pos_s3 <= t_pos_s2;
		end
	end

	// Stage 4: speed update against the last speed command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_s4 <= '0;
		end else if (en4 && v3) begin
			speed_s4 <= limit_sign(s_step_s3, speed_s4, s_ceil_s3, s_neg_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3) begin
			t_step_s4 <= t_step_s3;
			t_dir_ceil_s4 <= t_dir_ceil_s3;
			t_fast_ceil_s4 <= t_fast_ceil_s3;
			t_pos_s4 <= t_pos_s3;
		end
	end

	// Stage 5: near top speed the steering ceiling drops to the fast limit.
	always_comb begin
		v_mag = mag17(speed_s4);
		vmax_now = speed_s4[CMD_W-1] ? max_speed_rev_q : max_speed_fwd_q;
		v_mag_x5 = {v_mag, 2'b00} + (MAG_W + 3)'(v_mag);
		vmax_x4 = (MAG_W + 3)'({vmax_now, 2'b00});
		fast = (speed_s4 != '0) && (v_mag_x5 >= vmax_x4);
		amax_sel = fast ? t_fast_ceil_s4 : t_dir_ceil_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_s5 <= '0;
		end else if (en5 && v4) begin
			steer_s5 <= limit_sign(t_step_s4, steer_s5, amax_sel, t_pos_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v4) begin
			speed_s5 <= speed_s4;
		end
	end

	assign cmd_out.valid = v5;
	assign cmd_out.speed_cmd = speed_s5;
	assign cmd_out.steer_cmd = steer_s5;

`ifndef SYNTHESIS
	// The speed state moves only when an item enters stage 4.
	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en4 && v3) |=> $stable(speed_s4))
		else $error("speed state changed without an item");

	// The steering state moves only when an item enters stage 5.
	a_steer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en5 && v4) |=> $stable(steer_s5))
		else $error("steering state changed without an item");

	// With the output stage empty the whole pipeline can move.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v5 |-> cmd_in.ready)
		else $error("input stalled with an empty output stage");
`endif

endmodule
